>>> design/lru_frame_replacer_macros.svh
// Assertion macros for the replacer's top-level RTL file.
`ifndef LRU_FRAME_REPLACER_MACROS_SVH
`define LRU_FRAME_REPLACER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRUFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRUFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lrufr_pkg.sv
// Package for the LRU frame replacer: sizes, command codes and payload types.
package lrufr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = 8;
  localparam int CNT_W      = 9;
  localparam int CMD_W      = 2;
  localparam int FIDX_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FRAME_W-1:0] frame;
  } in_t;

  typedef struct packed {
    logic               victim_found;
    logic [FRAME_W-1:0] victim_frame;
    logic [CNT_W-1:0]   unpinned_count;
  } out_t;

  // Contents of one list cell
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               valid;
  } cell_t;

  // Per-cell control from the list controller
  typedef struct packed {
    logic shift;   // take the neighbour's contents (toward the head)
    logic append;  // write the new frame if this cell is the tail slot
  } cell_ctl_t;

endpackage

>>> design/lru_frame_replacer.sv
// LRU frame replacer: a row of cells holding evictable frames, oldest at the head.
//
// Usage: commands arrive on the in_ channel (valid/ready) as {command, frame}:
// victim takes the head frame, pin removes a frame, unpin appends a frame at
// the tail unless it is already listed. Frames at or above NUM_FRAMES are
// ignored by pin and unpin. Each command yields one result on the out_
// channel: {victim_found, victim_frame, unpinned_count}.
// Result: registered, valid in the cycle after the command transfer.
// Throughput: one command per cycle while results are taken. All cells compare
// the frame in parallel and the shifting cells move in the same cycle; membership
// is the OR of the cell matches, so the row updates in a single step per command.
// Stalls: the result sits in an output register; a new command is taken in
// the cycle the held result is transferred, and in_ready drops while the
// register holds an untaken result.
// Reset (rst_n, synchronous, active low): the list is empty, all frames are
// unlisted, the count is zero and no result is pending.
`include "lru_frame_replacer_macros.svh"

module lru_frame_replacer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lrufr_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lrufr_pkg::out_t out_data
);
  import lrufr_pkg::*;

  cell_t                   cell_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]   valid_vec;
  logic [NUM_FRAMES-1:0]   match_vec;
  logic [NUM_FRAMES-1:0]   shift_vec;
  logic                    append;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  out_t                    out_r, out_nxt;
  logic                    in_fire;
  logic                    in_range;
  logic                    any_match;
  logic                    is_listed;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Frame range check; membership comes from the parallel cell match
  assign in_range  = ({1'b0, in_data.frame} < CNT_W'(NUM_FRAMES));
  assign any_match = |match_vec;
  assign is_listed = in_range && any_match;

  // Command decode and list control
  always_comb begin
    shift_vec  = '0;
    append     = 1'b0;
    count_nxt  = count_r;
    out_nxt    = '{victim_found: 1'b0, victim_frame: '0, unpinned_count: count_r};
    if (in_fire) begin
      case (in_data.command)
        CMD_VICTIM: begin
          if (count_r != '0) begin
            shift_vec  = '1;
            count_nxt  = count_r - CNT_W'(1);
            out_nxt.victim_found = 1'b1;
            out_nxt.victim_frame = cell_q[0].frame;
          end
        end
        CMD_PIN: begin
          if (is_listed) begin
            // Cells from the matching one onward move toward the head
            shift_vec        = ~(match_vec - NUM_FRAMES'(1));
            count_nxt        = count_r - CNT_W'(1);
          end
        end
        CMD_UNPIN: begin
          if (in_range && !any_match && (count_r < CNT_W'(NUM_FRAMES))) begin
            append           = 1'b1;
            count_nxt        = count_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
      out_nxt.unpinned_count = count_nxt;
    end
  end

  // Cell row
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    logic      prev_valid;
    cell_t     next_q;
    cell_ctl_t ctl;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_vec[i-1];
    end

    if (i == NUM_FRAMES - 1) begin : g_last
      assign next_q = '{frame: '0, valid: 1'b0};
    end else begin : g_mid
      assign next_q = cell_q[i+1];
    end

    assign ctl = '{shift: shift_vec[i], append: append};

    lrufr_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .wr_frame   (in_data.frame),
      .prev_valid (prev_valid),
      .next_q     (next_q),
      .q          (cell_q[i]),
      .match      (match_vec[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  // Listed count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
    end else begin
      count_r  <= count_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `LRUFR_ASSERT_NOW(a_count_cells, 1'b1, $countones(valid_vec) == 32'(count_r),
                    "cell count mismatch")
  `LRUFR_ASSERT_NOW(a_single_match, 1'b1, $onehot0(match_vec), "frame held by two cells")
  `LRUFR_ASSERT_NOW(a_packed_head, 1'b1, (valid_vec & (valid_vec + NUM_FRAMES'(1))) == '0,
                    "cells not packed at head")
  `LRUFR_ASSERT_NEXT(a_victim_zero, in_fire && (in_data.command != CMD_VICTIM),
                     !out_data.victim_found && (out_data.victim_frame == '0),
                     "victim reported for non-victim command")

endmodule

>>> design/lrufr_cell.sv
// One list cell: holds a frame, matches it, shifts toward the head or takes an append.
module lrufr_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrufr_pkg::cell_ctl_t                ctl,
  input  logic [lrufr_pkg::FRAME_W-1:0]       wr_frame,
  input  logic                                prev_valid,
  input  lrufr_pkg::cell_t                    next_q,
  output lrufr_pkg::cell_t                    q,
  output logic                                match
);
  import lrufr_pkg::*;

  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               valid_r, valid_nxt;
  logic               is_tail;

  // Tail slot: first empty cell, at the head or behind a full one
  assign is_tail = !valid_r && prev_valid;

  always_comb begin
    frame_nxt = frame_r;
    valid_nxt = valid_r;
    if (ctl.shift) begin
      frame_nxt = next_q.frame;
      valid_nxt = next_q.valid;
    end else if (ctl.append && is_tail) begin
      frame_nxt = wr_frame;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Frame payload, no reset
  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  assign q     = '{frame: frame_r, valid: valid_r};
  assign match = valid_r && (frame_r == wr_frame);

endmodule

>>> sim/tb_lru_frame_replacer.sv
// Self-checking testbench for the LRU frame replacer: random commands against a queue-based predictor.
module tb_lru_frame_replacer;
  timeunit 1ns;
  timeprecision 1ps;

  import lrufr_pkg::*;

  // Code left unused by the block; must change nothing
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1800;
  localparam int MAX_WAIT     = 12;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Commands waiting to be offered, and results still owed by the block
  in_t  pending_q[$];
  out_t owed_q[$];

  // Predictor state: eviction order (head first) and membership flags
  logic [FRAME_W-1:0] evict_order[$];
  logic               frame_listed[NUM_FRAMES];

  int total_items;
  int accepted;
  int errors;
  int cycles;
  int cmd_seen[4];
  int evictions;
  int peak_len;

  lru_frame_replacer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the predicted list and return the result it should give
  function automatic out_t apply_command(in_t item);
    out_t res;
    res = '0;
    cmd_seen[item.command]++;
    case (item.command)
      CMD_VICTIM: begin
        if (evict_order.size() != 0) begin
          res.victim_found = 1'b1;
          res.victim_frame = evict_order.pop_front();
          frame_listed[res.victim_frame] = 1'b0;
          evictions++;
        end
      end
      CMD_PIN: begin
        if (item.frame < NUM_FRAMES && frame_listed[item.frame]) begin
          foreach (evict_order[i]) begin
            if (evict_order[i] == item.frame) begin
              evict_order.delete(i);
              break;
            end
          end
          frame_listed[item.frame] = 1'b0;
        end
      end
      CMD_UNPIN: begin
        if (item.frame < NUM_FRAMES && !frame_listed[item.frame] &&
            evict_order.size() < NUM_FRAMES) begin
          evict_order.insert(evict_order.size(), item.frame);
          frame_listed[item.frame] = 1'b1;
        end
      end
      default: ;
    endcase
    if (evict_order.size() > peak_len) peak_len = evict_order.size();
    res.unpinned_count = CNT_W'(evict_order.size());
    return res;
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] c, logic [FRAME_W-1:0] f);
    in_t item;
    item.command = c;
    item.frame   = f;
    pending_q.insert(pending_q.size(), item);
  endtask

  // Something the block should ignore: spare code or out-of-range frame
  task automatic queue_noise();
    case ($urandom_range(0, 2))
      0: queue_cmd(CMD_SPARE, FRAME_W'($urandom_range(0, 255)));
      1: queue_cmd(CMD_PIN, FRAME_W'($urandom_range(NUM_FRAMES, 255)));
      default: queue_cmd(CMD_UNPIN, FRAME_W'($urandom_range(NUM_FRAMES, 255)));
    endcase
  endtask

  // Sender: offers queued commands with a random gap after each transfer
  int tx_gap;
  bit tx_steady;
  always @(posedge clk) begin : tx_side
    int g;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (in_valid && in_ready) begin
      owed_q.insert(owed_q.size(), apply_command(in_data));
      accepted++;
      g = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
      if (g == 0 && pending_q.size() != 0) begin
        in_data <= pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
        tx_gap   <= (g > 0) ? g - 1 : 0;
      end
    end else if (!in_valid) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
      end else if (pending_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_q.pop_front();
      end
    end
  end

  // Receiver: random stall after each transfer, two long holds to back up the block
  int rx_stall;
  int rx_seen;
  bit rx_steady;
  always @(posedge clk) begin : rx_side
    int g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall  <= 0;
      rx_seen   <= 0;
    end else if (out_valid && out_ready) begin
      rx_seen <= rx_seen + 1;
      if (rx_seen == 400 || rx_seen == 1300) begin
        out_ready <= 1'b0;
        rx_stall  <= LONG_HOLD;
      end else begin
        g = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (g != 0) begin
          out_ready <= 1'b0;
          rx_stall  <= g;
        end
      end
      if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
    end else if (!out_ready) begin
      if (rx_stall > 1) begin
        rx_stall <= rx_stall - 1;
      end else begin
        rx_stall  <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest owed result
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got %h", $time, out_data);
      end else begin
        want = owed_q.pop_front();
        if (out_data.victim_found !== want.victim_found) begin
          errors++;
          $display("%0t: victim_found: expected %0d, got %0d", $time,
                   want.victim_found, out_data.victim_found);
        end
        if (out_data.victim_frame !== want.victim_frame) begin
          errors++;
          $display("%0t: victim_frame: expected %0d, got %0d", $time,
                   want.victim_frame, out_data.victim_frame);
        end
        if (out_data.unpinned_count !== want.unpinned_count) begin
          errors++;
          $display("%0t: unpinned_count: expected %0d, got %0d", $time,
                   want.unpinned_count, out_data.unpinned_count);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("lru_frame_replacer verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int perm[NUM_FRAMES];
    int j;
    int tmp;
    int r;
    foreach (frame_listed[i]) frame_listed[i] = 1'b0;

    // Directed: empty list, range edges, repeats, removal from middle and tail
    queue_cmd(CMD_VICTIM, 8'd0);
    queue_cmd(CMD_PIN, 8'd0);
    queue_cmd(CMD_UNPIN, 8'd0);
    queue_cmd(CMD_UNPIN, 8'(NUM_FRAMES - 1));
    queue_cmd(CMD_UNPIN, 8'(NUM_FRAMES));
    queue_cmd(CMD_UNPIN, 8'd255);
    queue_cmd(CMD_PIN, 8'd255);
    queue_cmd(CMD_UNPIN, 8'd0);
    queue_cmd(CMD_UNPIN, 8'd31);
    queue_cmd(CMD_PIN, 8'd5);
    queue_cmd(CMD_PIN, 8'(NUM_FRAMES - 1));
    queue_cmd(CMD_SPARE, 8'hAA);
    queue_cmd(CMD_SPARE, 8'h55);
    queue_cmd(CMD_PIN, 8'd31);
    queue_cmd(CMD_VICTIM, 8'hFF);
    queue_cmd(CMD_VICTIM, 8'd0);
    queue_cmd(CMD_UNPIN, 8'd7);
    queue_cmd(CMD_VICTIM, 8'd0);

    // Random episodes: fill to full, mixed traffic, drain
    while (pending_q.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: begin
          foreach (perm[i]) perm[i] = i;
          for (int i = NUM_FRAMES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          foreach (perm[i]) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            queue_cmd(CMD_UNPIN, FRAME_W'(perm[i]));
          end
        end
        1: begin
          repeat (100) begin
            r = $urandom_range(0, 99);
            if (r < 40) queue_cmd(CMD_UNPIN, FRAME_W'($urandom_range(0, NUM_FRAMES - 1)));
            else if (r < 65) queue_cmd(CMD_PIN, FRAME_W'($urandom_range(0, NUM_FRAMES - 1)));
            else if (r < 90) queue_cmd(CMD_VICTIM, FRAME_W'($urandom_range(0, 255)));
            else queue_noise();
          end
        end
        default: begin
          repeat (80) begin
            r = $urandom_range(0, 99);
            if (r < 55) queue_cmd(CMD_VICTIM, FRAME_W'($urandom_range(0, 255)));
            else if (r < 85) queue_cmd(CMD_PIN, FRAME_W'($urandom_range(0, NUM_FRAMES - 1)));
            else queue_noise();
          end
        end
      endcase
    end
    total_items = pending_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything offered, everything returned, then a few quiet cycles
    while (accepted < total_items) @(posedge clk);
    while (owed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d commands: %0d victim, %0d pin, %0d unpin, %0d spare code.",
             accepted, cmd_seen[CMD_VICTIM], cmd_seen[CMD_PIN], cmd_seen[CMD_UNPIN],
             cmd_seen[CMD_SPARE]);
    $display("Longest list held %0d frames; %0d frames evicted; %0d mismatches.",
             peak_len, evictions, errors);
    if (errors == 0) begin
      $display("lru_frame_replacer verification clean");
    end else begin
      $display("lru_frame_replacer verification failed");
    end
    $finish;
  end

endmodule
